@@ rtl/mme_pkg.sv @@
// Shared types, codes and sizes of the matrix multiply engine.
`default_nettype none

package mme_pkg;

    // Default largest matrix dimension (entries per store: MAX_DIM * MAX_DIM)
    localparam int MAX_DIM_DEF = 16;

    // Depths of the command and result queues
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    // Field widths fixed by the interface
    localparam int OP_W   = 2;
    localparam int IDX_W  = 4;
    localparam int ELEM_W = 16;
    localparam int SIZE_W = 5;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int DOT_W  = 36;
    localparam int CFG_IDX_W = 2;

    // Operation codes on the input side
    localparam logic [OP_W-1:0] OP_WR_A = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_B = 2'd1;
    localparam logic [OP_W-1:0] OP_DOT  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    // Command kinds between front and back
    localparam logic [1:0] CMD_WR_A = 2'd0;
    localparam logic [1:0] CMD_WR_B = 2'd1;
    localparam logic [1:0] CMD_DOT  = 2'd2;
    localparam logic [1:0] CMD_ERR  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]               kind;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [ELEM_W-1:0] value;
        logic [SIZE_W-1:0]        k;      // effective inner size, for a dot command
    } cmd_t;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic                    err;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/mme_fifo.sv @@
// Small synchronous FIFO used for the command and result queues.
`default_nettype none

module mme_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mme_front.sv @@
// Front end: size registers, operation decode and index range checks.
`default_nettype none

module mme_front #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mme_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mme_pkg::SIZE_W-1:0]          cfg_data,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [mme_pkg::OP_W-1:0]            operation,
    input  wire logic [mme_pkg::IDX_W-1:0]           row,
    input  wire logic [mme_pkg::IDX_W-1:0]           col,
    input  wire logic signed [mme_pkg::ELEM_W-1:0]   element_value,
    input  wire logic                                cmd_full,
    output logic                                     cmd_push,
    output mme_pkg::cmd_t                            cmd
);

    logic [mme_pkg::SIZE_W-1:0] rows_a_reg, inner_reg, cols_b_reg;
    logic [mme_pkg::SIZE_W-1:0] eff_m, eff_k, eff_n;
    logic [mme_pkg::SIZE_W-1:0] row_x, col_x;
    logic                       bad;
    logic                       cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign full      = cmd_full;

    // Sizes above the store dimension act as the store dimension
    assign eff_m = (int'(rows_a_reg) > MAX_DIM) ? mme_pkg::SIZE_W'(MAX_DIM) : rows_a_reg;
    assign eff_k = (int'(inner_reg)  > MAX_DIM) ? mme_pkg::SIZE_W'(MAX_DIM) : inner_reg;
    assign eff_n = (int'(cols_b_reg) > MAX_DIM) ? mme_pkg::SIZE_W'(MAX_DIM) : cols_b_reg;

    assign row_x = {1'b0, row};
    assign col_x = {1'b0, col};

    always_comb
    begin
        case (operation)
            mme_pkg::OP_WR_A: bad = (row_x >= eff_m) || (col_x >= eff_k);
            mme_pkg::OP_WR_B: bad = (row_x >= eff_k) || (col_x >= eff_n);
            mme_pkg::OP_DOT:  bad = (row_x >= eff_m) || (col_x >= eff_n);
            default:          bad = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd.row   = row;
        cmd.col   = col;
        cmd.value = element_value;
        cmd.k     = eff_k;
        case (operation)
            mme_pkg::OP_WR_A: cmd.kind = mme_pkg::CMD_WR_A;
            mme_pkg::OP_WR_B: cmd.kind = mme_pkg::CMD_WR_B;
            default:          cmd.kind = mme_pkg::CMD_DOT;
        endcase
        if (bad)
        begin
            cmd.kind = mme_pkg::CMD_ERR;
        end
    end

    // Unused operation code is dropped here
    assign cmd_push = push && !cmd_full && (operation != mme_pkg::OP_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= mme_pkg::SIZE_RESET;
            inner_reg  <= mme_pkg::SIZE_RESET;
            cols_b_reg <= mme_pkg::SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                mme_pkg::CFG_ROWS_A: rows_a_reg <= cfg_data;
                mme_pkg::CFG_INNER:  inner_reg  <= cfg_data;
                mme_pkg::CFG_COLS_B: cols_b_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/mme_back.sv @@
// Back end: A/B element stores and the multiply-accumulate sequencer.
`default_nettype none

module mme_back #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_empty,
    input  wire mme_pkg::cmd_t cmd,
    output logic               cmd_pop,
    input  wire logic          res_full,
    output logic               res_push,
    output mme_pkg::res_t      res_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic signed [mme_pkg::ELEM_W-1:0] mem_a [DEPTH];
    logic signed [mme_pkg::ELEM_W-1:0] mem_b [DEPTH];

    logic [1:0]                        state_reg, state_next;
    logic [mme_pkg::SIZE_W-1:0]        cnt_reg, cnt_next;
    logic [AW-1:0]                     a_addr_reg, a_addr_next;
    logic [AW-1:0]                     b_addr_reg, b_addr_next;
    logic signed [mme_pkg::DOT_W-1:0]  acc_reg, acc_next;
    logic signed [mme_pkg::DOT_W-1:0]  sum_full;
    logic signed [mme_pkg::ELEM_W-1:0] rd_a_reg, rd_b_reg;
    logic signed [mme_pkg::PROD_W-1:0] prod_reg;
    logic                              rd_v_reg, rd_last_reg;
    logic                              prod_v_reg, prod_last_reg;
    logic                              issue, last_issue;
    logic                              we_a, we_b;
    logic [AW-1:0]                     wr_addr;

    assign wr_addr  = AW'(int'(cmd.row) * MAX_DIM + int'(cmd.col));
    assign sum_full = acc_reg + mme_pkg::DOT_W'(prod_reg);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        acc_next    = acc_reg;
        cmd_pop     = 1'b0;
        we_a        = 1'b0;
        we_b        = 1'b0;
        res_push    = 1'b0;
        res_data    = '0;
        issue       = 1'b0;
        last_issue  = 1'b0;

        if (prod_v_reg)
        begin
            acc_next = sum_full;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Result queue space is checked up front: one result per command at most
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        mme_pkg::CMD_WR_A: we_a = 1'b1;
                        mme_pkg::CMD_WR_B: we_b = 1'b1;
                        mme_pkg::CMD_ERR:
                        begin
                            res_push     = 1'b1;
                            res_data.err = 1'b1;
                        end
                        mme_pkg::CMD_DOT:
                        begin
                            if (cmd.k == '0)
                            begin
                                res_push = 1'b1;
                            end
                            else
                            begin
                                a_addr_next = AW'(int'(cmd.row) * MAX_DIM);
                                b_addr_next = AW'(cmd.col);
                                cnt_next    = cmd.k;
                                acc_next    = '0;
                                state_next  = ST_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                // A walks along the row, B walks down the column
                issue       = 1'b1;
                a_addr_next = a_addr_reg + 1'b1;
                b_addr_next = b_addr_reg + AW'(MAX_DIM);
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == mme_pkg::SIZE_W'(1))
                begin
                    last_issue = 1'b1;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (prod_v_reg && prod_last_reg)
                begin
                    res_push     = 1'b1;
                    res_data.dot = sum_full;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_v_reg      <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_v_reg    <= 1'b0;
            prod_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_v_reg      <= issue;
            rd_last_reg   <= last_issue;
            prod_v_reg    <= rd_v_reg;
            prod_last_reg <= rd_v_reg && rd_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
        acc_reg    <= acc_next;
        if (rd_v_reg)
        begin
            prod_reg <= rd_a_reg * rd_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[wr_addr] <= cmd.value;
        end
        if (issue)
        begin
            rd_a_reg <= mem_a[a_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            mem_b[wr_addr] <= cmd.value;
        end
        if (issue)
        begin
            rd_b_reg <= mem_b[b_addr_reg];
        end
    end

endmodule

`default_nettype wire

@@ rtl/matrix_multiply_engine.sv @@
// Top level of the matrix multiply engine: front end, command queue, back end, result queue.
//
// Usage:
//   Input queue: drive operation/row/col/element_value with push; a transfer happens
//   at a clock edge with push high and full low. Operation 0 writes A[row][col],
//   1 writes B[row][col], 2 asks for result element (row, col), 3 is dropped.
//   Result queue: while empty is low the oldest result sits on dot_product and
//   index_error; pop high at a clock edge takes it. Writes in range give no result;
//   an out-of-range write or compute gives dot_product 0 with index_error 1.
//   Config port: cfg_valid/cfg_ready with cfg_index (0 rows_a, 1 inner_size,
//   2 cols_b) and cfg_data; cfg_ready is always high. Write only while idle.
// Timing:
//   A write is done in the back end as its command is popped. A compute of inner size K occupies the
//   single multiply-accumulate unit (K reads of the A and B stores, one per cycle,
//   plus read and multiply pipeline), after which its sum goes into the result queue.
//   An error result is pushed as its command is popped.
//   A four-entry command queue lets the input keep taking items while a compute runs.
// Reset clears queues and sets all sizes to 16; the stores are not cleared.
// When the result queue is full the back end stops taking commands; once the
// command queue fills, full rises and holds off new input.
`default_nettype none

module matrix_multiply_engine #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mme_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mme_pkg::SIZE_W-1:0]          cfg_data,
    // input item queue
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [mme_pkg::OP_W-1:0]            operation,
    input  wire logic [mme_pkg::IDX_W-1:0]           row,
    input  wire logic [mme_pkg::IDX_W-1:0]           col,
    input  wire logic signed [mme_pkg::ELEM_W-1:0]   element_value,
    // result queue
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [mme_pkg::DOT_W-1:0]         dot_product,
    output logic                                     index_error
);

    mme_pkg::cmd_t cmd_wr, cmd_rd;
    mme_pkg::res_t res_wr, res_rd;
    logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic          res_push, res_full;

    // Decode, range check and size registers
    mme_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .row           (row),
        .col           (col),
        .element_value (element_value),
        .cmd_full      (cmd_full),
        .cmd_push      (cmd_push),
        .cmd           (cmd_wr)
    );

    // Decouples the front end from the multiply-accumulate sequencer
    mme_fifo #(
        .WIDTH ($bits(mme_pkg::cmd_t)),
        .DEPTH (mme_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_wr),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rd),
        .empty   (cmd_empty)
    );

    // Stores plus one MAC per cycle
    mme_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_rd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_wr)
    );

    // Two-entry result queue; holds results while the receiver stalls
    mme_fifo #(
        .WIDTH ($bits(mme_pkg::res_t)),
        .DEPTH (mme_pkg::RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wr),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign dot_product = res_rd.dot;
    assign index_error = res_rd.err;

    // The back end must never hand a result to a full queue
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full result queue");

    // An index error result always carries a zero sum
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && index_error) |-> (dot_product == '0))
        else $error("index error result with nonzero dot product");

    // A popped command is always one the queue actually held
    a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");

endmodule

`default_nettype wire
